>>> hw/rtl/htc_pkg.sv
// Shared constants, register map and controller/datapath bundles for the
// hall throttle with cruise hold block. No dependencies.
package htc_pkg;

    // Sample and fixed-point format of the low-pass filter
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;
    localparam int SMOOTH_W      = SAMPLE_BITS + FRACTION_BITS;
    localparam int PEAK_W        = SAMPLE_BITS + 1;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int PCT_W      = 7;
    localparam int ALPHA_W    = 9;
    localparam int DB_W       = 10;
    localparam int DEBOUNCE_W = 16;
    localparam int ELAPSED_W  = 8;

    // Filter weight is in 1/256 units
    localparam int ALPHA_SHIFT = 8;
    localparam int ALPHA_HALF  = 1 << (ALPHA_SHIFT - 1);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_SHIFT);
    localparam int ROUND_HALF  = 1 << (FRACTION_BITS - 1);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // Shared divider: quotient bits and operand widths
    localparam int QUOT_W     = PCT_W;
    localparam int DIV_NUM_W  = SMOOTH_W + PCT_W;
    localparam int DIV_DEN_W  = PEAK_W + FRACTION_BITS;

    // APB register port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [ALPHA_W-1:0]     RST_FILTER_ALPHA    = ALPHA_W'(31);
    localparam logic [SAMPLE_BITS-1:0] RST_MIN_SPAN        = SAMPLE_BITS'(700);
    localparam logic [DB_W-1:0]        RST_NOISE_DEADBAND  = DB_W'(25);
    localparam logic [SAMPLE_BITS-1:0] RST_LEARN_THRESHOLD = SAMPLE_BITS'(80);
    localparam logic [PCT_W-1:0]       RST_INPUT_DB_PCT    = PCT_W'(2);
    localparam logic [PCT_W-1:0]       RST_MOTOR_START_PCT = PCT_W'(15);
    localparam logic [DEBOUNCE_W-1:0]  RST_DEBOUNCE_MS     = DEBOUNCE_W'(60);

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_RECAPTURE = 2'd1,
        CMD_LOAD_REST = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    // Register indexes (word address)
    typedef enum logic [2:0] {
        REG_FILTER_ALPHA    = 3'd0,
        REG_MIN_SPAN        = 3'd1,
        REG_NOISE_DEADBAND  = 3'd2,
        REG_LEARN_THRESHOLD = 3'd3,
        REG_INPUT_DB_PCT    = 3'd4,
        REG_MOTOR_START_PCT = 3'd5,
        REG_DEBOUNCE_MS     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]     filter_alpha;
        logic [SAMPLE_BITS-1:0] min_span;
        logic [DB_W-1:0]        noise_deadband;
        logic [SAMPLE_BITS-1:0] learn_threshold;
        logic [PCT_W-1:0]       input_deadband_pct;
        logic [PCT_W-1:0]       motor_start_pct;
        logic [DEBOUNCE_W-1:0]  debounce_ms;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic ld_in;
        logic filt;
        logic peak;
        logic start_thr;
        logic set_thr;
        logic start_map;
        logic set_map;
        logic rest_cap;
        logic rest_load;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic map_zero;
    } dp_sts_t;

endpackage

>>> hw/rtl/htc_in_if.sv
// Input channel for sensor beats: valid/ready handshake with item payload.
// Depends on htc_pkg.
interface htc_in_if import htc_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [SAMPLE_BITS-1:0] hall_sample;
    logic                   button_level;
    logic [ELAPSED_W-1:0]   elapsed_ms;

    modport source (
        output valid, command, hall_sample, button_level, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, command, hall_sample, button_level, elapsed_ms,
        output ready
    );

endinterface

>>> hw/rtl/htc_out_if.sv
// Output channel for result beats: valid/ready handshake with result payload.
// Depends on htc_pkg.
interface htc_out_if import htc_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [PCT_W-1:0]       throttle_pct;
    logic [PCT_W-1:0]       drive_pct;
    logic                   cruise_on;
    logic                   peak_learned;
    logic [SAMPLE_BITS-1:0] filtered_level;

    modport source (
        output valid, throttle_pct, drive_pct, cruise_on, peak_learned, filtered_level,
        input  ready
    );

    modport sink (
        input  valid, throttle_pct, drive_pct, cruise_on, peak_learned, filtered_level,
        output ready
    );

endinterface

>>> hw/rtl/htc_cfg_regs.sv
// APB configuration registers of the hall throttle block.
// Depends on htc_pkg.
module htc_cfg_regs
    import htc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FILTER_ALPHA:    cfg_next.filter_alpha       = pwdata[ALPHA_W-1:0];
                REG_MIN_SPAN:        cfg_next.min_span           = pwdata[SAMPLE_BITS-1:0];
                REG_NOISE_DEADBAND:  cfg_next.noise_deadband     = pwdata[DB_W-1:0];
                REG_LEARN_THRESHOLD: cfg_next.learn_threshold    = pwdata[SAMPLE_BITS-1:0];
                REG_INPUT_DB_PCT:    cfg_next.input_deadband_pct = pwdata[PCT_W-1:0];
                REG_MOTOR_START_PCT: cfg_next.motor_start_pct    = pwdata[PCT_W-1:0];
                REG_DEBOUNCE_MS:     cfg_next.debounce_ms        = pwdata[DEBOUNCE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha       <= RST_FILTER_ALPHA;
            cfg_reg.min_span           <= RST_MIN_SPAN;
            cfg_reg.noise_deadband     <= RST_NOISE_DEADBAND;
            cfg_reg.learn_threshold    <= RST_LEARN_THRESHOLD;
            cfg_reg.input_deadband_pct <= RST_INPUT_DB_PCT;
            cfg_reg.motor_start_pct    <= RST_MOTOR_START_PCT;
            cfg_reg.debounce_ms        <= RST_DEBOUNCE_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            REG_FILTER_ALPHA:    prdata = APB_DATA_W'(cfg_reg.filter_alpha);
            REG_MIN_SPAN:        prdata = APB_DATA_W'(cfg_reg.min_span);
            REG_NOISE_DEADBAND:  prdata = APB_DATA_W'(cfg_reg.noise_deadband);
            REG_LEARN_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.learn_threshold);
            REG_INPUT_DB_PCT:    prdata = APB_DATA_W'(cfg_reg.input_deadband_pct);
            REG_MOTOR_START_PCT: prdata = APB_DATA_W'(cfg_reg.motor_start_pct);
            REG_DEBOUNCE_MS:     prdata = APB_DATA_W'(cfg_reg.debounce_ms);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/htc_div.sv
// Restoring divider, one quotient bit per cycle, with an overflow flag for
// quotients too large for the result width. Depends on htc_pkg.
module htc_div
    import htc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [QUOT_W-1:0]    quot,
    output logic                 sat
);

    localparam int TRIAL_W = DIV_DEN_W + QUOT_W - 1;
    localparam int REM_W   = (TRIAL_W > DIV_NUM_W) ? TRIAL_W : DIV_NUM_W;
    localparam int STEP_W  = $clog2(QUOT_W);
    localparam int WIDE_W  = DIV_DEN_W + QUOT_W;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  trial_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              sat_reg;
    logic              fits;

    assign done = done_reg;
    assign quot = quot_reg;
    assign sat  = sat_reg;
    assign fits = rem_reg >= trial_reg;

    // Step sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder, shifted divisor and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= REM_W'(num);
            trial_reg <= REM_W'({den, {(QUOT_W - 1){1'b0}}});
            quot_reg  <= '0;
            sat_reg   <= WIDE_W'(num) >= {den, {QUOT_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial_reg;
            end
            quot_reg  <= {quot_reg[QUOT_W-2:0], fits};
            trial_reg <= trial_reg >> 1;
        end
    end

endmodule

>>> hw/rtl/htc_datapath.sv
// Datapath: filter, peak learning, throttle scaling, command map, button
// debounce, cruise hold and result register. Depends on htc_pkg and htc_div.
module htc_datapath
    import htc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  dp_cmd_t                cmd,
    output dp_sts_t                sts,
    input  logic [SAMPLE_BITS-1:0] hall_sample,
    input  logic                   button_level,
    input  logic [ELAPSED_W-1:0]   elapsed_ms,
    output logic [PCT_W-1:0]       throttle_pct,
    output logic [PCT_W-1:0]       drive_pct,
    output logic                   cruise_on,
    output logic                   peak_learned,
    output logic [SAMPLE_BITS-1:0] filtered_level
);

    localparam int FLT_W    = SMOOTH_W + ALPHA_W + 2;
    localparam int FX_W     = PEAK_W + FRACTION_BITS;
    localparam int MAP_W    = 2 * PCT_W;

    // Latched input beat
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   level_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;

    // Block state
    logic [SMOOTH_W-1:0]    smooth_reg;
    logic [SAMPLE_BITS-1:0] rest_reg;
    logic [PEAK_W-1:0]      peak_reg;
    logic                   peak_valid_reg;
    logic                   raw_btn_reg;
    logic                   steady_btn_reg;
    logic [DEBOUNCE_W-1:0]  quiet_reg;
    logic                   cruise_reg;
    logic                   toggle_on_reg;
    logic [PCT_W-1:0]       held_reg;
    logic [PCT_W-1:0]       throttle_reg;
    logic [PCT_W-1:0]       drive_reg;

    // Intermediate results of one tick
    logic [DIV_NUM_W-1:0]   num_reg;
    logic                   above_reg;

    // Result register
    logic [PCT_W-1:0]       out_thr_reg;
    logic [PCT_W-1:0]       out_drv_reg;
    logic                   out_cruise_reg;
    logic                   out_peak_reg;
    logic [SAMPLE_BITS-1:0] out_level_reg;

    logic [ALPHA_W-1:0]       alpha_eff;
    logic signed [SMOOTH_W:0] flt_diff;
    logic signed [FLT_W-1:0]  flt_prod;
    logic signed [FLT_W-1:0]  flt_round;
    logic signed [FLT_W-1:0]  flt_step;
    logic [SMOOTH_W:0]        rnd_sum;
    logic [SAMPLE_BITS-1:0]   rounded;
    logic [PEAK_W-1:0]        lt_sum;
    logic [PEAK_W-1:0]        fl_sum;
    logic [FX_W-1:0]          learn_fx;
    logic [FX_W-1:0]          peak_fx;
    logic [FX_W-1:0]          floor_fx;
    logic                     learn_hit;
    logic                     above;
    logic [SMOOTH_W-1:0]      num_diff;
    logic [DIV_NUM_W-1:0]     num_prod;
    logic [PEAK_W-1:0]        eff_span;
    logic [PEAK_W-1:0]        peak_diff;
    logic [PEAK_W-1:0]        span;
    logic [DEBOUNCE_W:0]      quiet_sum;
    logic                     press_accept;
    logic [PCT_W-1:0]         start_eff;
    logic [MAP_W-1:0]         map_prod;
    logic [PCT_W-1:0]         mapped;
    logic [PCT_W-1:0]         thr_value;
    logic [SAMPLE_BITS-1:0]   rest_new;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic                     div_sat;

    // Low-pass filter step: s + round((x - s) * alpha / 256)
    always_comb
    begin
        if (cfg.filter_alpha == '0)
            alpha_eff = ALPHA_W'(1);
        else if (cfg.filter_alpha > ALPHA_ONE)
            alpha_eff = ALPHA_ONE;
        else
            alpha_eff = cfg.filter_alpha;
        flt_diff  = $signed({1'b0, sample_reg, {FRACTION_BITS{1'b0}}})
                  - $signed({1'b0, smooth_reg});
        flt_prod  = flt_diff * $signed({1'b0, alpha_eff});
        flt_round = flt_prod + $signed(FLT_W'(ALPHA_HALF));
        flt_step  = flt_round >>> ALPHA_SHIFT;
    end

    // Filter value rounded to an integer
    assign rnd_sum = {1'b0, smooth_reg} + (SMOOTH_W + 1)'(ROUND_HALF);
    assign rounded = rnd_sum[SMOOTH_W-1:FRACTION_BITS];

    // Peak learning and travel above the noise floor
    assign lt_sum    = {1'b0, rest_reg} + {1'b0, cfg.learn_threshold};
    assign fl_sum    = {1'b0, rest_reg} + PEAK_W'(cfg.noise_deadband);
    assign learn_fx  = {lt_sum, {FRACTION_BITS{1'b0}}};
    assign peak_fx   = {peak_reg, {FRACTION_BITS{1'b0}}};
    assign floor_fx  = {fl_sum, {FRACTION_BITS{1'b0}}};
    assign learn_hit = (FX_W'(smooth_reg) > learn_fx) && (FX_W'(smooth_reg) > peak_fx);
    assign above     = FX_W'(smooth_reg) > floor_fx;
    assign num_diff  = smooth_reg - floor_fx[SMOOTH_W-1:0];
    assign num_prod  = DIV_NUM_W'(num_diff) * DIV_NUM_W'(PCT_FULL);

    // Full-scale span: the larger of the minimum span and the learned travel
    always_comb
    begin
        eff_span  = (cfg.min_span == '0) ? PEAK_W'(1) : {1'b0, cfg.min_span};
        peak_diff = peak_reg - {1'b0, rest_reg};
        if ((peak_reg > {1'b0, rest_reg}) && (peak_diff > eff_span))
            span = peak_diff;
        else
            span = eff_span;
    end

    // Throttle percent: zero at or below the noise floor, else clamped at full scale
    always_comb
    begin
        if (!above_reg)
            thr_value = '0;
        else if (div_sat || (div_quot > PCT_FULL))
            thr_value = PCT_FULL;
        else
            thr_value = div_quot;
    end

    // Button debounce
    assign quiet_sum    = {1'b0, quiet_reg} + (DEBOUNCE_W + 1)'(elapsed_reg);
    assign press_accept = (quiet_reg >= cfg.debounce_ms) && (level_reg != steady_btn_reg);

    // Command map: start + (t - db) * (100 - start) / (100 - db)
    assign start_eff    = (cfg.motor_start_pct > PCT_FULL) ? PCT_FULL : cfg.motor_start_pct;
    assign sts.map_zero = (cfg.input_deadband_pct >= PCT_FULL)
                       || (throttle_reg <= cfg.input_deadband_pct);
    assign map_prod     = MAP_W'(throttle_reg - cfg.input_deadband_pct)
                        * MAP_W'(PCT_FULL - start_eff);
    assign mapped       = sts.map_zero ? '0 : (start_eff + div_quot);

    // Shared divider operands
    always_comb
    begin
        if (cmd.start_map)
        begin
            div_num = DIV_NUM_W'(map_prod);
            div_den = DIV_DEN_W'(PCT_FULL - cfg.input_deadband_pct);
        end
        else
        begin
            div_num = num_reg;
            div_den = {span, {FRACTION_BITS{1'b0}}};
        end
    end

    htc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_thr || cmd.start_map),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    assign sts.div_done = div_done;

    // New rest level for the two rest commands
    assign rest_new = cmd.rest_cap ? rounded : sample_reg;

    // Block state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg     <= '0;
            rest_reg       <= '0;
            peak_reg       <= '0;
            peak_valid_reg <= 1'b0;
            raw_btn_reg    <= 1'b0;
            steady_btn_reg <= 1'b0;
            quiet_reg      <= '0;
            cruise_reg     <= 1'b0;
            toggle_on_reg  <= 1'b0;
            held_reg       <= '0;
            throttle_reg   <= '0;
            drive_reg      <= '0;
        end
        else
        begin
            if (cmd.filt)
            begin
                smooth_reg <= smooth_reg + flt_step[SMOOTH_W-1:0];
                if (level_reg != raw_btn_reg)
                begin
                    raw_btn_reg <= level_reg;
                    quiet_reg   <= '0;
                end
                else if (quiet_sum[DEBOUNCE_W])
                begin
                    quiet_reg <= '1;
                end
                else
                begin
                    quiet_reg <= quiet_sum[DEBOUNCE_W-1:0];
                end
            end
            if (cmd.peak && learn_hit)
            begin
                peak_reg       <= {1'b0, rounded};
                peak_valid_reg <= 1'b1;
            end
            if (cmd.set_thr)
            begin
                throttle_reg  <= thr_value;
                toggle_on_reg <= press_accept && level_reg && !cruise_reg;
                if (press_accept)
                begin
                    steady_btn_reg <= level_reg;
                    if (level_reg)
                        cruise_reg <= !cruise_reg;
                end
            end
            if (cmd.set_map)
            begin
                if (toggle_on_reg)
                    held_reg <= mapped;
                if (!cruise_reg)
                    drive_reg <= mapped;
                else if (toggle_on_reg)
                    drive_reg <= mapped;
                else
                    drive_reg <= held_reg;
            end
            if (cmd.rest_cap || cmd.rest_load)
            begin
                rest_reg       <= rest_new;
                peak_reg       <= {1'b0, rest_new} + eff_span;
                peak_valid_reg <= 1'b0;
                if (cmd.rest_load)
                    smooth_reg <= {sample_reg, {FRACTION_BITS{1'b0}}};
            end
        end
    end

    // Input latch, scaled travel and result register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            sample_reg  <= hall_sample;
            level_reg   <= button_level;
            elapsed_reg <= elapsed_ms;
        end
        if (cmd.peak)
        begin
            above_reg <= above;
            num_reg   <= num_prod;
        end
        if (cmd.out_load)
        begin
            out_thr_reg    <= throttle_reg;
            out_drv_reg    <= drive_reg;
            out_cruise_reg <= cruise_reg;
            out_peak_reg   <= peak_valid_reg;
            out_level_reg  <= rounded;
        end
    end

    assign throttle_pct   = out_thr_reg;
    assign drive_pct      = out_drv_reg;
    assign cruise_on      = out_cruise_reg;
    assign peak_learned   = out_peak_reg;
    assign filtered_level = out_level_reg;

endmodule

>>> hw/rtl/htc_ctrl.sv
// Controller state machine: sequences the datapath through one item and
// owns the input and output handshakes. Depends on htc_pkg.
module htc_ctrl
    import htc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_command,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  dp_sts_t          sts,
    output dp_cmd_t          cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_PEAK,
        ST_TSTART,
        ST_TDIV,
        ST_TSET,
        ST_MSTART,
        ST_MDIV,
        ST_MSET,
        ST_RCAP,
        ST_RLOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state, datapath commands and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in = 1'b1;
                    unique case (cmd_t'(in_command))
                        CMD_TICK:      state_next = ST_FILT;
                        CMD_RECAPTURE: state_next = ST_RCAP;
                        CMD_LOAD_REST: state_next = ST_RLOAD;
                        CMD_NOP:       state_next = ST_EMIT;
                    endcase
                end
            end
            ST_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = ST_PEAK;
            end
            ST_PEAK:
            begin
                cmd.peak   = 1'b1;
                state_next = ST_TSTART;
            end
            ST_TSTART:
            begin
                cmd.start_thr = 1'b1;
                state_next    = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (sts.div_done)
                    state_next = ST_TSET;
            end
            ST_TSET:
            begin
                cmd.set_thr = 1'b1;
                state_next  = ST_MSTART;
            end
            ST_MSTART:
            begin
                if (sts.map_zero)
                begin
                    state_next = ST_MSET;
                end
                else
                begin
                    cmd.start_map = 1'b1;
                    state_next    = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                if (sts.div_done)
                    state_next = ST_MSET;
            end
            ST_MSET:
            begin
                cmd.set_map = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_RCAP:
            begin
                cmd.rest_cap = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_RLOAD:
            begin
                cmd.rest_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/hall_throttle_with_cruise_hold_top.sv
// Hall throttle with cruise hold. A sensor tick is accepted in the idle cycle and its
// result beat is loaded once the output register is free; a new item is taken the
// cycle after the result is registered. A tick runs two divisions in turn on the shared
// one-bit-per-cycle divider, the second skipped when the command map gives zero. Rest
// and spare items skip both. The result register lets the next item in while a result
// waits. rst_n clears control, config and block state asynchronously; no memories.
module hall_throttle_with_cruise_hold_top
    import htc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    htc_in_if.sink                sensor,
    htc_out_if.source             report,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Configuration registers
    htc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing and handshakes
    htc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sensor.valid),
        .in_command (sensor.command),
        .in_ready   (sensor.ready),
        .out_ready  (report.ready),
        .out_valid  (report.valid),
        .sts        (dp_sts),
        .cmd        (dp_cmd)
    );

    // Arithmetic and block state
    htc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (dp_cmd),
        .sts            (dp_sts),
        .hall_sample    (sensor.hall_sample),
        .button_level   (sensor.button_level),
        .elapsed_ms     (sensor.elapsed_ms),
        .throttle_pct   (report.throttle_pct),
        .drive_pct      (report.drive_pct),
        .cruise_on      (report.cruise_on),
        .peak_learned   (report.peak_learned),
        .filtered_level (report.filtered_level)
    );

endmodule
